FILE: hw/rtl/utf8_fold_slug_stream_defines.svh
// Assertion macros shared by the slug stream RTL.
// No dependencies; included by the top level.
`ifndef UTF8_FOLD_SLUG_STREAM_DEFINES_SVH
`define UTF8_FOLD_SLUG_STREAM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UFS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ufs assertion failed");

// Next-cycle implication, disabled during reset.
`define UFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ufs assertion failed");

`endif

FILE: hw/rtl/ufs_pkg.sv
// Shared constants, types and character functions for the slug stream.
// No dependencies.
package ufs_pkg;

  localparam int NAME_CAPACITY = 32;
  localparam int SLUG_LIMIT    = (NAME_CAPACITY - 1 > 31) ? 31 : NAME_CAPACITY - 1;
  localparam int HELD_DEPTH    = 31;
  localparam int HELD_AW       = $clog2(HELD_DEPTH);
  localparam int COUNT_W       = 5;

  typedef logic [1:0] mark_t;
  localparam mark_t MARK_UNDER = 2'd0;
  localparam mark_t MARK_DASH  = 2'd1;
  localparam mark_t MARK_DOT   = 2'd2;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_IDLE       = 2'd0;
  localparam phase_t PH_TWO        = 2'd1;
  localparam phase_t PH_THREE      = 2'd2;
  localparam phase_t PH_THREE_CONT = 2'd3;

  localparam logic [6:0] CH_UNDER = 7'h5f;
  localparam logic [6:0] CH_DASH  = 7'h2d;
  localparam logic [6:0] CH_DOT   = 7'h2e;

  typedef struct packed {
    logic load;
    logic decode;
    logic sep;
    logic append;
    logic flush_emit;
    logic char_emit;
    logic end_emit;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic alnum;
    logic room;
    logic held_nz;
    logic flush_last;
    logic out_free;
    logic last;
  } status_t;

  function automatic logic is_alnum(input logic [6:0] c);
    return (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5a) ||
           (c >= 7'h61 && c <= 7'h7a);
  endfunction

  function automatic logic is_mark(input logic [6:0] c);
    return (c == CH_UNDER) || (c == CH_DASH) || (c == CH_DOT);
  endfunction

  function automatic mark_t mark_of(input logic [6:0] c);
    mark_t m;
    if (c == CH_UNDER) m = MARK_UNDER;
    else if (c == CH_DASH) m = MARK_DASH;
    else m = MARK_DOT;
    return m;
  endfunction

  function automatic logic [6:0] mark_char(input mark_t m);
    logic [6:0] c;
    case (m)
      MARK_UNDER: c = CH_UNDER;
      MARK_DASH:  c = CH_DASH;
      MARK_DOT:   c = CH_DOT;
      default:    c = CH_UNDER;
    endcase
    return c;
  endfunction

  // Code point to ASCII; 0 when the code point has no folding.
  function automatic logic [6:0] fold_char(input logic [15:0] cp);
    logic [6:0] up;
    logic [6:0] c;
    up = 7'h59;
    c  = 7'h00;
    if (cp < 16'h0080) begin
      c = cp[6:0];
    end else if (cp >= 16'h1ea0 && cp <= 16'h1ef9) begin
      if (cp <= 16'h1eb7) up = 7'h41;
      else if (cp <= 16'h1ec7) up = 7'h45;
      else if (cp <= 16'h1ecb) up = 7'h49;
      else if (cp <= 16'h1ee3) up = 7'h4f;
      else if (cp <= 16'h1ef1) up = 7'h55;
      else up = 7'h59;
      c = cp[0] ? up + 7'd32 : up;
    end else begin
      case (cp)
        16'h00c0, 16'h00c1, 16'h00c2, 16'h00c3, 16'h0102: c = 7'h41;
        16'h00e0, 16'h00e1, 16'h00e2, 16'h00e3, 16'h0103: c = 7'h61;
        16'h0110: c = 7'h44;
        16'h0111: c = 7'h64;
        16'h00c8, 16'h00c9, 16'h00ca: c = 7'h45;
        16'h00e8, 16'h00e9, 16'h00ea: c = 7'h65;
        16'h00cc, 16'h00cd, 16'h0128: c = 7'h49;
        16'h00ec, 16'h00ed, 16'h0129: c = 7'h69;
        16'h00d2, 16'h00d3, 16'h00d4, 16'h00d5, 16'h01a0: c = 7'h4f;
        16'h00f2, 16'h00f3, 16'h00f4, 16'h00f5, 16'h01a1: c = 7'h6f;
        16'h00d9, 16'h00da, 16'h0168, 16'h01af: c = 7'h55;
        16'h00f9, 16'h00fa, 16'h0169, 16'h01b0: c = 7'h75;
        16'h00dd: c = 7'h59;
        16'h00fd: c = 7'h79;
        default:  c = 7'h00;
      endcase
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/ufs_in_if.sv
// Input channel: one byte of the name per transaction.
// No dependencies.
interface ufs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

FILE: hw/rtl/ufs_out_if.sv
// Output channel: one slug character or the end item per transaction.
// No dependencies.
interface ufs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] slug_char;
  logic       is_end;
  logic [4:0] slug_length;

  modport source (output valid, output slug_char, output is_end, output slug_length,
                  input ready);
  modport sink   (input valid, input slug_char, input is_end, input slug_length,
                  output ready);
endinterface

FILE: hw/rtl/ufs_ctrl.sv
// Controller state machine: sequences decode, separator, append, flush and emit.
// Depends on ufs_pkg.
module ufs_ctrl
  import ufs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SEP    = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;
  localparam logic [2:0] S_CHAR   = 3'd5;
  localparam logic [2:0] S_END    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (st.take) state_next = S_SEP;
        else state_next = st.last ? S_END : S_IDLE;
      end
      S_SEP: begin
        cmd.sep    = 1'b1;
        state_next = S_APPEND;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        if (st.alnum && st.room) state_next = st.held_nz ? S_FLUSH : S_CHAR;
        else state_next = st.last ? S_END : S_IDLE;
      end
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.flush_emit = 1'b1;
          if (st.flush_last) state_next = S_CHAR;
        end
      end
      S_CHAR: begin
        if (st.out_free) begin
          cmd.char_emit = 1'b1;
          state_next    = st.last ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (st.out_free) begin
          cmd.end_emit = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ufs_dp.sv
// Datapath: UTF-8 decode, folding, held mark store, counters and output register.
// Depends on ufs_pkg.
module ufs_dp
  import ufs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [7:0]   in_byte,
  input  logic         in_last,
  input  cmd_t         cmd,
  output status_t      st,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [6:0]   slug_char,
  output logic         is_end,
  output logic [4:0]   slug_length
);

  logic [7:0]         byte_q;
  logic               last_q;
  logic [7:0]         lead;
  logic [7:0]         second;
  phase_t             phase;
  logic               sep;
  logic [COUNT_W-1:0] emitted;
  logic [COUNT_W-1:0] held;
  logic [HELD_AW-1:0] flush_idx;
  logic [6:0]         c_q;
  mark_t              held_marks [HELD_DEPTH];

  logic               cont;
  logic               start_take;
  logic               start_two;
  logic               start_three;
  logic               dec_take;
  logic [15:0]        dec_cp;
  phase_t             dec_phase;
  logic               dec_lead_load;
  logic               dec_second_load;
  logic               dec_sep;
  logic [6:0]         dec_c;
  logic               dec_ok;
  logic [COUNT_W:0]   total;
  logic               emit;
  logic [6:0]         emit_char;

  assign cont        = (byte_q[7:6] == 2'b10);
  assign start_take  = !byte_q[7];
  assign start_two   = (byte_q[7:5] == 3'b110);
  assign start_three = (byte_q[7:4] == 4'b1110);

  always_comb begin
    dec_take        = 1'b0;
    dec_cp          = {8'h00, byte_q};
    dec_phase       = PH_IDLE;
    dec_lead_load   = 1'b0;
    dec_second_load = 1'b0;
    dec_sep         = 1'b0;
    if (phase != PH_IDLE && cont) begin
      case (phase)
        PH_TWO: begin
          dec_take = 1'b1;
          dec_cp   = {5'd0, lead[4:0], byte_q[5:0]};
        end
        PH_THREE: begin
          dec_second_load = 1'b1;
          dec_phase       = PH_THREE_CONT;
        end
        default: begin
          dec_take = 1'b1;
          dec_cp   = {lead[3:0], second[5:0], byte_q[5:0]};
        end
      endcase
    end else begin
      dec_sep = (phase != PH_IDLE);
      if (start_take) begin
        dec_take = 1'b1;
      end else if (start_two) begin
        dec_lead_load = 1'b1;
        dec_phase     = PH_TWO;
      end else if (start_three) begin
        dec_lead_load = 1'b1;
        dec_phase     = PH_THREE;
      end else begin
        dec_sep = 1'b1;
      end
    end
  end

  assign dec_c  = fold_char(dec_cp);
  assign dec_ok = dec_take && (is_alnum(dec_c) || is_mark(dec_c));
  assign total  = {1'b0, emitted} + {1'b0, held};

  assign emit = cmd.flush_emit || cmd.char_emit || cmd.end_emit;
  assign emit_char = cmd.flush_emit ? mark_char(held_marks[flush_idx]) :
                     (cmd.char_emit ? c_q : 7'd0);

  always_comb begin
    st.take       = dec_ok;
    st.alnum      = is_alnum(c_q);
    st.room       = (total < (COUNT_W + 1)'(SLUG_LIMIT));
    st.held_nz    = (held != '0);
    st.flush_last = (({1'b0, flush_idx} + (HELD_AW + 1)'(1)) == (HELD_AW + 1)'(held));
    st.out_free   = !out_valid || out_ready;
    st.last       = last_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= in_byte;
      last_q <= in_last;
    end
    if (cmd.decode) c_q <= dec_c;
    if (cmd.sep && sep && total != '0 && total < (COUNT_W + 1)'(SLUG_LIMIT)) begin
      held_marks[held[HELD_AW-1:0]] <= MARK_UNDER;
    end
    if (cmd.append && is_mark(c_q) && total < (COUNT_W + 1)'(SLUG_LIMIT)) begin
      held_marks[held[HELD_AW-1:0]] <= mark_of(c_q);
    end
    if (emit) begin
      slug_char   <= emit_char;
      is_end      <= cmd.end_emit;
      slug_length <= cmd.end_emit ? emitted : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead      <= '0;
      second    <= '0;
      phase     <= PH_IDLE;
      sep       <= 1'b0;
      emitted   <= '0;
      held      <= '0;
      flush_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.decode) begin
        phase <= dec_phase;
        sep   <= sep | dec_sep | (dec_take & !dec_ok);
        if (dec_lead_load) lead <= byte_q;
        if (dec_second_load) second <= byte_q;
      end
      if (cmd.sep) begin
        sep <= 1'b0;
        if (sep && total != '0 && total < (COUNT_W + 1)'(SLUG_LIMIT)) held <= held + 1'b1;
      end
      if (cmd.append) begin
        flush_idx <= '0;
        if (is_mark(c_q) && total < (COUNT_W + 1)'(SLUG_LIMIT)) held <= held + 1'b1;
      end
      if (cmd.flush_emit) flush_idx <= flush_idx + 1'b1;
      if (cmd.char_emit) begin
        emitted <= emitted + held + 1'b1;
        held    <= '0;
      end
      if (cmd.end_emit) begin
        lead    <= '0;
        second  <= '0;
        phase   <= PH_IDLE;
        sep     <= 1'b0;
        emitted <= '0;
        held    <= '0;
      end
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/utf8_fold_slug_stream.sv
// UTF-8 name to ASCII slug converter, top level.
// Depends on ufs_pkg, ufs_in_if, ufs_out_if, ufs_ctrl, ufs_dp and the defines header.
//
// din carries one byte of the name per transaction (in_byte, is_last).
// dout carries one slug character per transaction; after the last byte of a
// name one end transaction follows with is_end set, slug_char 0 and
// slug_length the number of characters sent for that name.
// One byte is worked on at a time: din.ready is high only in the idle state.
// A byte that completes no character (part of a sequence, or one that only
// owes a separator) passes through accept and decode. A character that is
// kept passes through accept, decode, separator and append; a held mark, or
// one past the length limit, ends there. A letter or digit then emits the
// held marks, one per cycle while dout is not stalled, then the character.
// The end transaction is sent from a state of its own.
// Results sit in an output register, so a byte finishing without output
// never waits on dout; an emit waits while dout is stalled with a character
// pending, and nothing is lost or repeated.
// Reset (rst, synchronous, active high) returns the controller to idle,
// empties the output register and clears all per-name state.
`include "utf8_fold_slug_stream_defines.svh"

module utf8_fold_slug_stream
  import ufs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ufs_in_if.sink    din,
  ufs_out_if.source dout
);

  cmd_t    cmd;
  status_t st;

  ufs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .st       (st),
    .cmd      (cmd)
  );

  ufs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (din.in_byte),
    .in_last     (din.is_last),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (dout.valid),
    .out_ready   (dout.ready),
    .slug_char   (dout.slug_char),
    .is_end      (dout.is_end),
    .slug_length (dout.slug_length)
  );

  `UFS_ASSERT_NEXT(a_busy_after_accept, clk, rst, din.valid && din.ready, !din.ready)
  `UFS_ASSERT_NOW(a_end_item_blank, clk, rst, dout.valid && dout.is_end, dout.slug_char == 7'd0)
  `UFS_ASSERT_NOW(a_char_item_shape, clk, rst, dout.valid && !dout.is_end,
                  dout.slug_length == 5'd0 && dout.slug_char != 7'd0)

endmodule

FILE: bench/utf8_fold_slug_stream_test.sv
`timescale 1ns / 1ps
// Self-checking bench for utf8_fold_slug_stream: byte stream in, slug characters out.
// Depends on ufs_pkg, ufs_in_if, ufs_out_if and the utf8_fold_slug_stream top level.

module utf8_fold_slug_stream_test;
  import ufs_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int WD_LIMIT   = 4000;
  localparam int LONG_HOLD  = 400;
  localparam int NAME_LIMIT = (NAME_CAPACITY - 1 > 31) ? 31 : NAME_CAPACITY - 1;
  localparam int MARK_DEPTH = 31;

  localparam logic [15:0] FOLD_CPS [44] = '{
    16'h00c0, 16'h00c1, 16'h00c2, 16'h00c3, 16'h0102,
    16'h00e0, 16'h00e1, 16'h00e2, 16'h00e3, 16'h0103,
    16'h0110, 16'h0111,
    16'h00c8, 16'h00c9, 16'h00ca, 16'h00e8, 16'h00e9, 16'h00ea,
    16'h00cc, 16'h00cd, 16'h0128, 16'h00ec, 16'h00ed, 16'h0129,
    16'h00d2, 16'h00d3, 16'h00d4, 16'h00d5, 16'h01a0,
    16'h00f2, 16'h00f3, 16'h00f4, 16'h00f5, 16'h01a1,
    16'h00d9, 16'h00da, 16'h0168, 16'h01af,
    16'h00f9, 16'h00fa, 16'h0169, 16'h01b0,
    16'h00dd, 16'h00fd
  };

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       is_end;
    logic [4:0] len;
  } slug_out_t;

  bit clk;
  logic rst;

  ufs_in_if  din();
  ufs_out_if dout();

  utf8_fold_slug_stream u_top (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // slug predictor state
  phase_t      dec_phase;
  logic [7:0]  lead_b;
  logic [7:0]  mid_b;
  bit          sep_owed;
  int          sent_cnt;
  int          held_cnt;
  mark_t       held_q [MARK_DEPTH];
  slug_out_t   slug_expect_q[$];

  logic [7:0]  name_bytes[$];
  int          burst_left;
  bit          long_hold_req;
  int          stall_cycles;
  int          fail_count;
  int          names_sent;
  int          bytes_sent;
  int          chars_checked;
  int          ends_checked;
  int          full_slugs;
  slug_out_t   slug_want;

  function automatic logic [7:0] fold_to_ascii(input logic [15:0] cp);
    logic [7:0] base;
    if (cp < 16'h0080) return {1'b0, cp[6:0]};
    if (cp >= 16'h1ea0 && cp <= 16'h1ef9) begin
      if (cp <= 16'h1eb7) base = "A";
      else if (cp <= 16'h1ec7) base = "E";
      else if (cp <= 16'h1ecb) base = "I";
      else if (cp <= 16'h1ee3) base = "O";
      else if (cp <= 16'h1ef1) base = "U";
      else base = "Y";
      return cp[0] ? base + 8'd32 : base;
    end
    case (cp)
      16'h00c0, 16'h00c1, 16'h00c2, 16'h00c3, 16'h0102: return "A";
      16'h00e0, 16'h00e1, 16'h00e2, 16'h00e3, 16'h0103: return "a";
      16'h0110: return "D";
      16'h0111: return "d";
      16'h00c8, 16'h00c9, 16'h00ca: return "E";
      16'h00e8, 16'h00e9, 16'h00ea: return "e";
      16'h00cc, 16'h00cd, 16'h0128: return "I";
      16'h00ec, 16'h00ed, 16'h0129: return "i";
      16'h00d2, 16'h00d3, 16'h00d4, 16'h00d5, 16'h01a0: return "O";
      16'h00f2, 16'h00f3, 16'h00f4, 16'h00f5, 16'h01a1: return "o";
      16'h00d9, 16'h00da, 16'h0168, 16'h01af: return "U";
      16'h00f9, 16'h00fa, 16'h0169, 16'h01b0: return "u";
      16'h00dd: return "Y";
      16'h00fd: return "y";
      default: return 8'd0;
    endcase
  endfunction

  function automatic bit slug_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit slug_mark(input logic [7:0] c);
    return c == "_" || c == "-" || c == ".";
  endfunction

  function automatic mark_t mark_code(input logic [7:0] c);
    if (c == "_") return MARK_UNDER;
    if (c == "-") return MARK_DASH;
    return MARK_DOT;
  endfunction

  function automatic logic [6:0] mark_ascii(input mark_t m);
    case (m)
      MARK_DASH: return CH_DASH;
      MARK_DOT:  return CH_DOT;
      default:   return CH_UNDER;
    endcase
  endfunction

  function void push_slug_char(input logic [6:0] c);
    slug_expect_q.push_back('{ch: c, is_end: 1'b0, len: 5'd0});
  endfunction

  function void slug_append(input logic [7:0] c);
    if (sent_cnt + held_cnt >= NAME_LIMIT) return;
    if (!slug_alnum(c)) begin
      if (held_cnt < MARK_DEPTH) begin
        held_q[held_cnt] = mark_code(c);
        held_cnt++;
      end
      return;
    end
    for (int i = 0; i < held_cnt; i++) push_slug_char(mark_ascii(held_q[i]));
    sent_cnt += held_cnt;
    held_cnt = 0;
    push_slug_char(c[6:0]);
    sent_cnt++;
  endfunction

  function void take_code_point(input logic [15:0] cp);
    logic [7:0] c;
    c = fold_to_ascii(cp);
    if (c != 8'd0 && (slug_alnum(c) || slug_mark(c))) begin
      if (sep_owed && sent_cnt + held_cnt > 0) slug_append("_");
      sep_owed = 1'b0;
      slug_append(c);
    end else begin
      sep_owed = 1'b1;
    end
  endfunction

  function void start_lead(input logic [7:0] b);
    if (b < 8'h80) begin
      take_code_point({8'd0, b});
    end else if (b[7:5] == 3'b110) begin
      lead_b    = b;
      dec_phase = PH_TWO;
    end else if (b[7:4] == 4'b1110) begin
      lead_b    = b;
      dec_phase = PH_THREE;
    end else begin
      sep_owed = 1'b1;
    end
  endfunction

  function void slug_clear();
    lead_b    = 8'd0;
    mid_b     = 8'd0;
    dec_phase = PH_IDLE;
    sep_owed  = 1'b0;
    sent_cnt  = 0;
    held_cnt  = 0;
  endfunction

  function void slug_step(input logic [7:0] b, input bit last);
    bit cont;
    cont = (b[7:6] == 2'b10);
    case (dec_phase)
      PH_IDLE: start_lead(b);
      PH_TWO: begin
        dec_phase = PH_IDLE;
        if (cont) take_code_point({5'd0, lead_b[4:0], b[5:0]});
        else begin
          sep_owed = 1'b1;
          start_lead(b);
        end
      end
      PH_THREE: begin
        if (cont) begin
          mid_b     = b;
          dec_phase = PH_THREE_CONT;
        end else begin
          dec_phase = PH_IDLE;
          sep_owed  = 1'b1;
          start_lead(b);
        end
      end
      default: begin
        dec_phase = PH_IDLE;
        if (cont) take_code_point({lead_b[3:0], mid_b[5:0], b[5:0]});
        else begin
          sep_owed = 1'b1;
          start_lead(b);
        end
      end
    endcase
    if (last) begin
      slug_expect_q.push_back('{ch: 7'd0, is_end: 1'b1, len: sent_cnt[4:0]});
      slug_clear();
    end
  endfunction

  // name generation
  function void put_cp2(input logic [15:0] cp);
    name_bytes.push_back({3'b110, cp[10:6]});
    name_bytes.push_back({2'b10, cp[5:0]});
  endfunction

  function void put_cp3(input logic [15:0] cp);
    name_bytes.push_back({4'b1110, cp[15:12]});
    name_bytes.push_back({2'b10, cp[11:6]});
    name_bytes.push_back({2'b10, cp[5:0]});
  endfunction

  function void add_char(input int pick);
    int r;
    int run;
    r = $urandom_range(0, 61);
    if (pick < 30) begin
      if (r < 10) name_bytes.push_back(8'("0") + 8'(r));
      else if (r < 36) name_bytes.push_back(8'("A") + 8'(r - 10));
      else name_bytes.push_back(8'("a") + 8'(r - 36));
    end else if (pick < 45) begin
      run = $urandom_range(1, 4);
      repeat (run) begin
        case ($urandom_range(0, 2))
          0: name_bytes.push_back("_");
          1: name_bytes.push_back("-");
          default: name_bytes.push_back(".");
        endcase
      end
    end else if (pick < 55) begin
      name_bytes.push_back(8'($urandom_range(1, 127)));
    end else if (pick < 67) begin
      put_cp2(FOLD_CPS[$urandom_range(0, 43)]);
    end else if (pick < 75) begin
      put_cp3(16'($urandom_range(16'h1ea0, 16'h1ef9)));
    end else if (pick < 80) begin
      put_cp2(16'($urandom_range(16'h0080, 16'h07ff)));
    end else if (pick < 85) begin
      put_cp3(16'($urandom_range(0, 16'hffff)));
    end else if (pick < 88) begin
      put_cp2(16'($urandom_range(0, 16'h007f)));
    end else if (pick < 94) begin
      // truncated sequence
      if ($urandom_range(0, 1)) begin
        name_bytes.push_back(8'($urandom_range(8'hc0, 8'hdf)));
      end else begin
        name_bytes.push_back(8'($urandom_range(8'he0, 8'hef)));
        if ($urandom_range(0, 1)) name_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
      end
    end else if (pick < 97) begin
      name_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
    end else begin
      name_bytes.push_back(8'($urandom_range(8'hf0, 8'hff)));
    end
  endfunction

  function void build_name(input int nchars, input int pick_max);
    name_bytes.delete();
    repeat (nchars) add_char($urandom_range(0, pick_max));
  endfunction

  function void build_random_name();
    if ($urandom_range(0, 7) == 0) build_name($urandom_range(28, 45), 99);
    else build_name($urandom_range(1, 10), 99);
  endfunction

  // driving
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(20, 60);
      end else begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end
      if (gap > 0) begin
        din.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    din.valid   <= 1'b1;
    din.in_byte <= b;
    din.is_last <= last;
    do @(posedge clk); while (!din.ready);
    slug_step(b, last);
    bytes_sent++;
  endtask

  task automatic send_name();
    for (int i = 0; i < name_bytes.size(); i++)
      send_byte(name_bytes[i], i == name_bytes.size() - 1);
    names_sent++;
  endtask

  task automatic wait_drained();
    din.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (slug_expect_q.size() != 0);
  endtask

  // tests
  task automatic test_directed();
    // folded two- and three-byte letters, trailing marks dropped at the end
    name_bytes = '{8'hc3, 8'h80, 8'he1, 8'hbb, 8'hb9, 8'h2d, 8'h2e, 8'h5f};
    send_name();
    // separator with empty slug, bytes of 0xF0 and above, stray continuation,
    // overlong zero, DEL, lead cut short by ASCII, name ending mid-sequence
    name_bytes = '{8'h01, 8'h30, 8'hff, 8'h80, 8'h7a, 8'hc0, 8'h80, 8'h7f,
                   8'h5a, 8'he0, 8'h41, 8'hc4};
    send_name();
    // three-byte sequence broken after its first continuation
    name_bytes = '{8'hc4, 8'h91, 8'he1, 8'hba, 8'h41};
    send_name();
    // name of a lone mark gives an empty slug
    name_bytes = '{8'h2d};
    send_name();
  endtask

  task automatic test_capacity();
    build_name(40, 29);
    send_name();
    repeat (3) begin
      build_name($urandom_range(32, 48), 54);
      send_name();
    end
  endtask

  task automatic test_random(input int byte_target);
    while (bytes_sent < byte_target) begin
      build_random_name();
      send_name();
    end
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (3) begin
      build_name($urandom_range(6, 14), 99);
      send_name();
    end
  endtask

  // receiver pacing
  initial begin : rx_pacing
    rx_mode_t mode;
    int left;
    mode = RX_OPEN;
    left = 0;
    dout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        dout.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        left = 0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(4, 40);
        end
        left--;
        case (mode)
          RX_OPEN:   dout.ready <= 1'b1;
          RX_COIN:   dout.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: dout.ready <= ($urandom_range(0, 3) == 0);
          default:   dout.ready <= ~dout.ready;
        endcase
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && dout.valid && dout.ready) begin
      if (slug_expect_q.size() == 0) begin
        $error("unexpected transaction: slug_char=%0h is_end=%0b slug_length=%0d",
               dout.slug_char, dout.is_end, dout.slug_length);
        fail_count++;
      end else begin
        slug_want = slug_expect_q.pop_front();
        if (dout.slug_char !== slug_want.ch) begin
          $error("slug_char: expected %0h, actual %0h", slug_want.ch, dout.slug_char);
          fail_count++;
        end
        if (dout.is_end !== slug_want.is_end) begin
          $error("is_end: expected %0b, actual %0b", slug_want.is_end, dout.is_end);
          fail_count++;
        end
        if (dout.slug_length !== slug_want.len) begin
          $error("slug_length: expected %0d, actual %0d", slug_want.len, dout.slug_length);
          fail_count++;
        end
        if (slug_want.is_end) begin
          ends_checked++;
          if (slug_want.len == NAME_LIMIT) full_slugs++;
        end else begin
          chars_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WD_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, slug_expect_q.size());
      $display("utf8_fold_slug_stream_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst         <= 1'b1;
    din.valid   <= 1'b0;
    din.in_byte <= 8'h41;
    din.is_last <= 1'b0;
    slug_clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    wait_drained();
    test_capacity();
    test_random(250);
    test_backpressure();
    wait_drained();
    test_random(340);

    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d names, %0d bytes: %0d slug characters and %0d end items checked",
             names_sent, bytes_sent, chars_checked, ends_checked);
    $display("%0d slugs reached the length limit, %0d mismatches", full_slugs, fail_count);
    if (fail_count == 0 && slug_expect_q.size() == 0) begin
      $display("utf8_fold_slug_stream_test: PASS");
    end else begin
      $display("utf8_fold_slug_stream_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ufs_pkg.sv
hw/rtl/ufs_in_if.sv
hw/rtl/ufs_out_if.sv
hw/rtl/ufs_ctrl.sv
hw/rtl/ufs_dp.sv
hw/rtl/utf8_fold_slug_stream.sv
bench/utf8_fold_slug_stream_test.sv
